>>> rtl/scb_pkg.sv
// scb_pkg: shared types and constants for the sphere/box contact core
// holds the input word and result word structs used by the core and its checker
// no dependencies
package scb_pkg;

  localparam int AXES            = 3;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 31;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        half_x;
    logic [30:0]        half_y;
    logic [30:0]        half_z;
    logic [30:0]        radius;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic               inside_res;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] depth;
  } result_t;

endpackage

>>> rtl/sphere_box_contact_core.sv
// sphere_box_contact_core: pipelined sphere vs box closest point contact test
// depends on scb_pkg for the item and result words
//
// Usage: one input word per cycle on item, taken at an edge where start is high
// and busy is low. busy is high only while rst is held, so after reset a new
// pair can enter every cycle. The user must write the breaking threshold
// register through thr_we / thr_data only while no pair is in flight; the
// block does not enforce this. It resets to zero. Each accepted word gives
// exactly one result word on result, shown for one cycle with result_valid
// high, in input order. Throughput is one pair per cycle. The pipeline
// holds the square root unit (32 stages, one root bit each) and the normal
// divider (31 stages, one quotient bit each, three lanes side by side), plus
// four front stages for capture, clamping, squaring and summing, one stage
// for the hit test and divider setup, and one output register.
// The receiver cannot stall, so the pipeline never holds; a synchronous reset
// clears every valid bit and drops all words in flight.
module sphere_box_contact_core #(
  parameter int COORD_WIDTH = scb_pkg::COORD_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  scb_pkg::item_t  item,
  input  logic            thr_we,
  input  logic [30:0]     thr_data,
  output logic            result_valid,
  output scb_pkg::result_t result
);

  localparam int SAT_W = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
  localparam logic signed [35:0] SAT_HI = (36'sd1 <<< (SAT_W - 1)) - 36'sd1;
  localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;
  localparam int NSQ = scb_pkg::SQRT_STEPS;
  localparam int NDV = scb_pkg::DIV_STEPS;

  typedef struct packed {
    logic [2:0][31:0] p;       // clamped point
    logic [2:0][31:0] in_p;    // point pushed out for the inside case
    logic [1:0]       axis;
    logic             ax_neg;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic signed [33:0] best;
    logic [30:0]      radius;
    logic [31:0]      margin;
  } side_t;

  function automatic logic [31:0] sat(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > SAT_HI) r = SAT_HI[31:0];
    else if (v < SAT_LO) r = SAT_LO[31:0];
    else r = v[31:0];
    return r;
  endfunction

  assign busy = rst;

  logic [30:0] thr;
  always_ff @(posedge clk) begin
    if (rst) thr <= '0;
    else if (thr_we) thr <= thr_data;
  end

  // stage a: capture
  logic           a_vld;
  scb_pkg::item_t a_item;
  logic [31:0]    a_margin;
  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else a_vld <= start & ~busy;
    a_item   <= item;
    a_margin <= {1'b0, item.radius} + {1'b0, thr};
  end

  // stage b: clamp and clearances
  logic signed [2:0][31:0] b_c_w;
  logic [2:0][30:0]        b_h_w;
  logic [2:0][31:0]        b_p_n, b_mag_n;
  logic [2:0]              b_neg_n, b_cneg_n;
  logic signed [33:0]      b_cl_n [3];
  always_comb begin
    logic signed [31:0] c, h, p;
    logic signed [32:0] d, ac;
    b_c_w = {a_item.center_z, a_item.center_y, a_item.center_x};
    b_h_w = {a_item.half_z, a_item.half_y, a_item.half_x};
    for (int i = 0; i < 3; i++) begin
      c = b_c_w[i];
      h = {1'b0, b_h_w[i]};
      if (c > h) p = h;
      else if (c < -h) p = -h;
      else p = c;
      d = {c[31], c} - {p[31], p};
      b_p_n[i]   = p;
      b_neg_n[i] = d[32];
      b_mag_n[i] = d[32] ? 32'(-d) : d[31:0];
      ac = c[31] ? -{c[31], c} : {c[31], c};
      b_cl_n[i]  = {2'b00, h} - {ac[32], ac};
      b_cneg_n[i] = c[31];
    end
  end

  logic               b_vld;
  logic [2:0][31:0]   b_p, b_mag;
  logic [2:0]         b_neg, b_cneg;
  logic [2:0][30:0]   b_h;
  logic signed [33:0] b_cl [3];
  logic [30:0]        b_radius;
  logic [31:0]        b_margin;
  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else b_vld <= a_vld;
    b_p      <= b_p_n;
    b_mag    <= b_mag_n;
    b_neg    <= b_neg_n;
    b_cneg   <= b_cneg_n;
    b_h      <= b_h_w;
    b_cl     <= b_cl_n;
    b_radius <= a_item.radius;
    b_margin <= a_margin;
  end

  // stage c: squares and inside axis choice
  side_t c_side_n;
  always_comb begin
    c_side_n.p      = b_p;
    c_side_n.mag    = b_mag;
    c_side_n.neg    = b_neg;
    c_side_n.radius = b_radius;
    c_side_n.margin = b_margin;
    c_side_n.axis   = 2'd0;
    c_side_n.best   = b_cl[0];
    if (b_cl[1] < c_side_n.best) begin
      c_side_n.axis = 2'd1;
      c_side_n.best = b_cl[1];
    end
    if (b_cl[2] < c_side_n.best) begin
      c_side_n.axis = 2'd2;
      c_side_n.best = b_cl[2];
    end
    c_side_n.ax_neg = b_cneg[c_side_n.axis];
    c_side_n.in_p   = b_p;
    c_side_n.in_p[c_side_n.axis] = c_side_n.ax_neg ? -{1'b0, b_h[c_side_n.axis]}
                                                   : {1'b0, b_h[c_side_n.axis]};
  end

  logic             c_vld;
  side_t            c_side;
  logic [2:0][63:0] c_sq;
  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else c_vld <= b_vld;
    c_side <= c_side_n;
    for (int i = 0; i < 3; i++) c_sq[i] <= b_mag[i] * b_mag[i];
  end

  // stage d: sum of squares, feeds the root pipeline at index 0
  logic        sq_vld  [NSQ+1];
  side_t       sq_side [NSQ+1];
  logic        sq_in   [NSQ+1];
  logic [35:0] sq_rem  [NSQ+1];
  logic [31:0] sq_root [NSQ+1];
  logic [63:0] sq_val  [NSQ+1];

  logic [63:0] d_sum;
  assign d_sum = c_sq[0] + c_sq[1] + c_sq[2];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else sq_vld[0] <= c_vld;
    sq_side[0] <= c_side;
    sq_in[0]   <= (d_sum == 64'd0);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_val[0]  <= d_sum;
  end

  // square root: one result bit per stage
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [35:0] r2, trial;
    logic        ge;
    assign r2    = {sq_rem[k][33:0], sq_val[k][63:62]};
    assign trial = {2'b00, sq_root[k], 2'b01};
    assign ge    = (r2 >= trial);
    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else sq_vld[k+1] <= sq_vld[k];
      sq_side[k+1] <= sq_side[k];
      sq_in[k+1]   <= sq_in[k];
      sq_rem[k+1]  <= ge ? (r2 - trial) : r2;
      sq_root[k+1] <= {sq_root[k][30:0], ge};
      sq_val[k+1]  <= {sq_val[k][61:0], 2'b00};
    end
  end

  // stage e: hit test and divider setup at index 0
  logic             dv_vld  [NDV+1];
  side_t            dv_side [NDV+1];
  logic             dv_in   [NDV+1];
  logic             dv_hit  [NDV+1];
  logic [31:0]      dv_dist [NDV+1];
  logic [2:0][32:0] dv_rem  [NDV+1];
  logic [2:0][30:0] dv_nb   [NDV+1];
  logic [2:0][30:0] dv_q    [NDV+1];

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else dv_vld[0] <= sq_vld[NSQ];
    dv_side[0] <= sq_side[NSQ];
    dv_in[0]   <= sq_in[NSQ];
    dv_hit[0]  <= (sq_root[NSQ] < sq_side[NSQ].margin);
    dv_dist[0] <= sq_root[NSQ];
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= {2'b00, sq_side[NSQ].mag[i][31:1]};
      dv_nb[0][i]  <= {sq_side[NSQ].mag[i][0], 30'd0};
      dv_q[0][i]   <= '0;
    end
  end

  // normal divider: one quotient bit per stage, three lanes
  for (genvar k = 0; k < NDV; k++) begin : g_div
    logic [2:0][32:0] r2;
    logic [2:0]       ge;
    for (genvar j = 0; j < 3; j++) begin : g_lane
      assign r2[j] = {dv_rem[k][j][31:0], dv_nb[k][j][30]};
      assign ge[j] = (r2[j] >= {1'b0, dv_dist[k]});
    end
    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else dv_vld[k+1] <= dv_vld[k];
      dv_side[k+1] <= dv_side[k];
      dv_in[k+1]   <= dv_in[k];
      dv_hit[k+1]  <= dv_hit[k];
      dv_dist[k+1] <= dv_dist[k];
      for (int j = 0; j < 3; j++) begin
        dv_rem[k+1][j] <= ge[j] ? (r2[j] - {1'b0, dv_dist[k]}) : r2[j];
        dv_nb[k+1][j]  <= {dv_nb[k][j][29:0], 1'b0};
        dv_q[k+1][j]   <= {dv_q[k][j][29:0], ge[j]};
      end
    end
  end

  // output assembly
  scb_pkg::result_t res_n;
  always_comb begin
    side_t              s;
    logic [2:0][31:0]   pt, nv;
    logic [30:0]        q;
    logic signed [35:0] dep;
    s   = dv_side[NDV];
    pt  = s.p;
    nv  = '0;
    q   = '0;
    dep = '0;
    if (dv_in[NDV]) begin
      pt = s.in_p;
      nv[s.axis] = s.ax_neg ? -scb_pkg::ONE_Q30 : scb_pkg::ONE_Q30;
      dep = -({{2{s.best[33]}}, s.best} + {5'd0, s.radius});
    end else begin
      for (int i = 0; i < 3; i++) begin
        q = dv_q[NDV][i];
        if (q > 31'h4000_0000) q = 31'h4000_0000;
        nv[i] = s.neg[i] ? -{1'b0, q} : {1'b0, q};
      end
      dep = {4'd0, dv_dist[NDV]} - {5'd0, s.radius};
    end
    res_n.hit        = dv_hit[NDV];
    res_n.inside_res = dv_in[NDV];
    res_n.point_x    = dv_hit[NDV] ? sat({{4{pt[0][31]}}, pt[0]}) : '0;
    res_n.point_y    = dv_hit[NDV] ? sat({{4{pt[1][31]}}, pt[1]}) : '0;
    res_n.point_z    = dv_hit[NDV] ? sat({{4{pt[2][31]}}, pt[2]}) : '0;
    res_n.normal_x   = dv_hit[NDV] ? nv[0] : '0;
    res_n.normal_y   = dv_hit[NDV] ? nv[1] : '0;
    res_n.normal_z   = dv_hit[NDV] ? nv[2] : '0;
    res_n.depth      = dv_hit[NDV] ? sat(dep) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= dv_vld[NDV];
    result <= res_n;
  end

endmodule

>>> rtl/scb_checker.sv
// scb_checker: port level assertions for sphere_box_contact_core
// depends on scb_pkg; bound to the core at the end of this file
module scb_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input scb_pkg::result_t result
);

  // reset drops every word in flight
  a_rst_flush: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

  // a miss reports all zero geometry
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |->
      (result.point_x == 0 && result.point_y == 0 && result.point_z == 0 &&
       result.normal_x == 0 && result.normal_y == 0 && result.normal_z == 0 &&
       result.depth == 0))
    else $error("miss with nonzero geometry");

  // inside hit pushes out along exactly one axis with a non-positive depth
  a_inside_axis: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.hit && result.inside_res) |->
      ($onehot({result.normal_x != 0, result.normal_y != 0, result.normal_z != 0}) &&
       result.depth <= 0))
    else $error("bad inside push out");

  // outside normal components stay within unit magnitude
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.hit && !result.inside_res) |->
      (result.normal_x <= 32'sh4000_0000 && result.normal_x >= -32'sh4000_0000 &&
       result.normal_y <= 32'sh4000_0000 && result.normal_y >= -32'sh4000_0000 &&
       result.normal_z <= 32'sh4000_0000 && result.normal_z >= -32'sh4000_0000))
    else $error("normal component above one");

  // every accepted word shows its result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##69 result_valid)
    else $error("missing result strobe");

endmodule

bind sphere_box_contact_core scb_checker u_scb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

>>> tb/testbench.sv
// testbench: self-checking bench for sphere_box_contact_core
// predicts each result word in software, checks words in order, sweeps the threshold
// depends on scb_pkg and the core
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 69;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  scb_pkg::item_t item = '0;
  logic thr_we = 1'b0;
  logic [30:0] thr_data = '0;
  logic result_valid;
  scb_pkg::result_t result;

  logic [30:0] threshold = '0;
  scb_pkg::result_t contact_q[$];
  int errors = 0;
  int idle_pct = 0;

  sphere_box_contact_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .thr_we(thr_we), .thr_data(thr_data),
    .result_valid(result_valid), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic scb_pkg::result_t predict_contact(scb_pkg::item_t w, logic [30:0] thr);
    longint c[3], h[3], p[3], d[3], n[3];
    longint rad, dep, best, cl, q;
    longint unsigned sum, root_len, margin, mag;
    logic ins, hit;
    int ax;
    scb_pkg::result_t r;
    c[0] = longint'(w.center_x); c[1] = longint'(w.center_y); c[2] = longint'(w.center_z);
    h[0] = longint'(w.half_x); h[1] = longint'(w.half_y); h[2] = longint'(w.half_z);
    rad = longint'(w.radius);
    sum = 0;
    dep = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = c[i] > h[i] ? h[i] : (c[i] < -h[i] ? -h[i] : c[i]);
      d[i] = c[i] - p[i];
      sum += longint'(d[i] * d[i]);
      n[i] = 0;
    end
    root_len = int_sqrt(sum);
    margin = longint'(rad) + longint'(thr);
    ins = (sum == 0);
    hit = root_len < margin;
    if (hit && !ins) begin
      dep = longint'(root_len) - rad;
      for (int i = 0; i < 3; i++) begin
        mag = d[i] < 0 ? -d[i] : d[i];
        q = longint'((mag << 30) / root_len);
        if (q > 64'sd1073741824) q = 64'sd1073741824;
        n[i] = d[i] < 0 ? -q : q;
      end
    end else if (hit) begin
      ax = 0;
      best = h[0] - (c[0] < 0 ? -c[0] : c[0]);
      for (int i = 1; i < 3; i++) begin
        cl = h[i] - (c[i] < 0 ? -c[i] : c[i]);
        if (cl < best) begin
          best = cl;
          ax = i;
        end
      end
      p[ax] = c[ax] >= 0 ? h[ax] : -h[ax];
      n[ax] = c[ax] >= 0 ? 64'sd1073741824 : -64'sd1073741824;
      dep = -(best + rad);
    end
    r.hit = hit;
    r.inside_res = ins;
    r.point_x = hit ? 32'(clamp32(p[0])) : 32'd0;
    r.point_y = hit ? 32'(clamp32(p[1])) : 32'd0;
    r.point_z = hit ? 32'(clamp32(p[2])) : 32'd0;
    r.normal_x = hit ? 32'(n[0]) : 32'd0;
    r.normal_y = hit ? 32'(n[1]) : 32'd0;
    r.normal_z = hit ? 32'(n[2]) : 32'd0;
    r.depth = hit ? 32'(clamp32(dep)) : 32'd0;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
  endtask

  // checker: every strobe pops the oldest prediction
  always @(posedge clk) begin
    scb_pkg::result_t e;
    if (!rst && result_valid) begin
      if (contact_q.size() == 0) begin
        report_mismatch("unexpected word", 32'd0, 32'd0);
      end else begin
        e = contact_q.pop_front();
        if (result.hit !== e.hit) report_mismatch("hit", 32'(result.hit), 32'(e.hit));
        if (result.inside_res !== e.inside_res)
          report_mismatch("inside_res", 32'(result.inside_res), 32'(e.inside_res));
        if (result.point_x !== e.point_x) report_mismatch("point_x", result.point_x, e.point_x);
        if (result.point_y !== e.point_y) report_mismatch("point_y", result.point_y, e.point_y);
        if (result.point_z !== e.point_z) report_mismatch("point_z", result.point_z, e.point_z);
        if (result.normal_x !== e.normal_x)
          report_mismatch("normal_x", result.normal_x, e.normal_x);
        if (result.normal_y !== e.normal_y)
          report_mismatch("normal_y", result.normal_y, e.normal_y);
        if (result.normal_z !== e.normal_z)
          report_mismatch("normal_z", result.normal_z, e.normal_z);
        if (result.depth !== e.depth) report_mismatch("depth", result.depth, e.depth);
      end
    end
  end

  task automatic send_pair(scb_pkg::item_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    contact_q.push_back(predict_contact(w, threshold));
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (contact_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(logic [30:0] v);
    drain_pipe();
    thr_we <= 1'b1;
    thr_data <= v;
    @(posedge clk);
    thr_we <= 1'b0;
    threshold = v;
  endtask

  function automatic scb_pkg::item_t make_pair(int kind);
    scb_pkg::item_t w;
    w.center_x = $urandom; w.center_y = $urandom; w.center_z = $urandom;
    w.half_x = 31'($urandom); w.half_y = 31'($urandom); w.half_z = 31'($urandom);
    w.radius = 31'($urandom);
    case (kind)
      0: begin
        // small scene near the box, mostly contacts
        w.half_x = 31'($urandom_range(0, 20) << 16);
        w.half_y = 31'($urandom_range(0, 20) << 16);
        w.half_z = 31'($urandom_range(0, 20) << 16);
        w.center_x = $signed($urandom_range(0, 60 << 16)) - (30 << 16);
        w.center_y = $signed($urandom_range(0, 60 << 16)) - (30 << 16);
        w.center_z = $signed($urandom_range(0, 60 << 16)) - (30 << 16);
        w.radius = 31'($urandom_range(0, 15 << 16));
      end
      1: begin
        // centre inside the box
        w.half_x = 31'($urandom_range(0, 32'h7fff_ffff));
        w.half_y = 31'($urandom_range(0, 32'h7fff_ffff));
        w.half_z = 31'($urandom_range(0, 32'h7fff_ffff));
        w.center_x = $urandom_range(0, w.half_x) * ($urandom_range(1) ? 1 : -1);
        w.center_y = $urandom_range(0, w.half_y) * ($urandom_range(1) ? 1 : -1);
        w.center_z = $urandom_range(0, w.half_z) * ($urandom_range(1) ? 1 : -1);
        if ($urandom_range(3) == 0) w.radius = 31'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic scb_pkg::item_t pair_of(longint cx, longint cy, longint cz,
                                             longint hx, longint hy, longint hz,
                                             longint r);
    scb_pkg::item_t w;
    w.center_x = 32'(cx); w.center_y = 32'(cy); w.center_z = 32'(cz);
    w.half_x = 31'(hx); w.half_y = 31'(hy); w.half_z = 31'(hz); w.radius = 31'(r);
    return w;
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 1));
    send_pair(pair_of(0, 0, 0, 5 << 16, 5 << 16, 5 << 16, 1 << 16));
    send_pair(pair_of(-(1 << 16), 0, 0, 3 << 16, 3 << 16, 3 << 16, 1 << 16));
    send_pair(pair_of(1 << 16, 1 << 16, 0, 2 << 16, 1 << 16, 3 << 16, 1 << 16));
    send_pair(pair_of(3 << 16, 0, 0, 2 << 16, 2 << 16, 2 << 16, 2 << 16));
    send_pair(pair_of(3 << 16, 3 << 16, 3 << 16, 2 << 16, 2 << 16, 2 << 16, 4 << 16));
    send_pair(pair_of(-(4 << 16), 0, 0, 2 << 16, 2 << 16, 2 << 16, 1 << 16));
    send_pair(pair_of(2 << 16, 0, 0, 2 << 16, 2 << 16, 2 << 16, 1));
    send_pair(pair_of(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                      0, 0, 0, 32'h7fff_ffff));
    send_pair(pair_of(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                      0, 0, 0, 32'h7fff_ffff));
    send_pair(pair_of(-64'sd2147483648, 64'sd2147483647, 0,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_pair(pair_of(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff));
    send_pair(pair_of(-64'sd2147483648, 0, 0, 32'h7fff_ffff, 0, 0, 1));
    send_pair(pair_of(10, 0, 0, 0, 0, 0, 10));
    send_pair(pair_of(-1, -1, -1, 0, 0, 0, 2));
  endtask

  task automatic test_threshold_edges();
    set_threshold(31'h7fff_ffff);
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                      0, 0, 0, 32'h7fff_ffff));
    send_pair(pair_of(1, 2, 3, 1, 1, 1, 0));
    set_threshold(31'd1);
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(1, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    repeat (count) send_pair(make_pair($urandom_range(0, 3) < 2 ? 0
                                      : ($urandom_range(1) ? 1 : 2)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_edges();
    set_threshold(31'd0);
    test_random(260, 0);
    set_threshold(31'(2 << 16));
    test_random(260, 53);
    set_threshold(31'($urandom));
    test_random(260, 19);
    set_threshold(31'h7fff_ffff);
    test_random(250, 0);
    drain_pipe();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && contact_q.size() == 0) begin
      $display("** sphere_box_contact_core: PASSED **");
    end else begin
      $display("** sphere_box_contact_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** sphere_box_contact_core: FAILED **");
    $finish;
  end

endmodule
